// ===== rtl/scl_pkg.sv =====
// Shared constants and codes for the crop / letterbox placement block.
// No dependencies; imported by every module under rtl/.
package scl_pkg;

    // scaler limits
    localparam int SRC_MIN_W   = 68;
    localparam int SRC_MIN_H   = 2;
    localparam int SRC_MAX     = 8176;
    localparam int DST_MIN_W   = 68;
    localparam int DST_MIN_H   = 2;
    localparam int DST_MAX     = 8128;
    localparam int OUT_W_ALIGN = 16;

    // APB register map: 8 registers at 4-byte spacing
    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 32;

    typedef enum logic [2:0] {
        REG_OUT_WIDTH  = 3'd0,
        REG_OUT_HEIGHT = 3'd1,
        REG_LBOX_EN    = 3'd2,
        REG_CROP_ON    = 3'd3,
        REG_CROP_X     = 3'd4,
        REG_CROP_Y     = 3'd5,
        REG_CROP_W     = 3'd6,
        REG_CROP_H     = 3'd7
    } t_reg_idx;

    typedef enum logic [2:0] {
        ERR_OK    = 3'd0,
        ERR_ALIGN = 3'd1,
        ERR_SRC   = 3'd2,
        ERR_DST   = 3'd3,
        ERR_SCALE = 3'd4
    } t_err;

endpackage

// ===== rtl/scl_cfg.sv =====
// APB configuration registers for the placement block.
// Depends on scl_pkg for the register map.
module scl_cfg #(
    parameter int W = 13
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [scl_pkg::PADDR_W-1:0] paddr,
    input  logic [scl_pkg::PDATA_W-1:0] pwdata,
    output logic [scl_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    output logic [W-1:0]                o_out_width,
    output logic [W-1:0]                o_out_height,
    output logic                        o_lbox_en,
    output logic                        o_crop_on,
    output logic [W-1:0]                o_crop_x,
    output logic [W-1:0]                o_crop_y,
    output logic [W-1:0]                o_crop_w,
    output logic [W-1:0]                o_crop_h
);
    import scl_pkg::*;

    logic [W-1:0] r_out_width, r_out_height, r_crop_x, r_crop_y, r_crop_w, r_crop_h;
    logic         r_lbox_en, r_crop_on;
    logic         wr_en;
    t_reg_idx     idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = t_reg_idx'(paddr[PADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_width  <= W'(640);
            r_out_height <= W'(480);
            r_lbox_en    <= 1'b0;
            r_crop_on    <= 1'b0;
            r_crop_x     <= '0;
            r_crop_y     <= '0;
            r_crop_w     <= '0;
            r_crop_h     <= '0;
        end else if (wr_en) begin
            unique case (idx)
                REG_OUT_WIDTH:  r_out_width  <= pwdata[W-1:0];
                REG_OUT_HEIGHT: r_out_height <= pwdata[W-1:0];
                REG_LBOX_EN:    r_lbox_en    <= pwdata[0];
                REG_CROP_ON:    r_crop_on    <= pwdata[0];
                REG_CROP_X:     r_crop_x     <= pwdata[W-1:0];
                REG_CROP_Y:     r_crop_y     <= pwdata[W-1:0];
                REG_CROP_W:     r_crop_w     <= pwdata[W-1:0];
                REG_CROP_H:     r_crop_h     <= pwdata[W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_OUT_WIDTH:  prdata = PDATA_W'(r_out_width);
            REG_OUT_HEIGHT: prdata = PDATA_W'(r_out_height);
            REG_LBOX_EN:    prdata = PDATA_W'(r_lbox_en);
            REG_CROP_ON:    prdata = PDATA_W'(r_crop_on);
            REG_CROP_X:     prdata = PDATA_W'(r_crop_x);
            REG_CROP_Y:     prdata = PDATA_W'(r_crop_y);
            REG_CROP_W:     prdata = PDATA_W'(r_crop_w);
            REG_CROP_H:     prdata = PDATA_W'(r_crop_h);
            default:        prdata = '0;
        endcase
    end

    assign o_out_width  = r_out_width;
    assign o_out_height = r_out_height;
    assign o_lbox_en    = r_lbox_en;
    assign o_crop_on    = r_crop_on;
    assign o_crop_x     = r_crop_x;
    assign o_crop_y     = r_crop_y;
    assign o_crop_w     = r_crop_w;
    assign o_crop_h     = r_crop_h;

endmodule

// ===== rtl/scl_front.sv =====
// Front pipeline: crop selection and clamping, source range check,
// aspect cross-products and divider operand selection. Uses scl_pkg.
module scl_front #(
    parameter int  W      = 13,
    localparam int SIDE_W = 4 * W + 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [W-1:0]      i_frame_width,
    input  logic [W-1:0]      i_frame_height,
    input  logic              i_dyn_crop_on,
    input  logic [W-1:0]      i_dyn_crop_x,
    input  logic [W-1:0]      i_dyn_crop_y,
    input  logic [W-1:0]      i_dyn_crop_w,
    input  logic [W-1:0]      i_dyn_crop_h,
    input  logic [W-1:0]      i_out_width,
    input  logic [W-1:0]      i_out_height,
    input  logic              i_crop_on,
    input  logic [W-1:0]      i_crop_x,
    input  logic [W-1:0]      i_crop_y,
    input  logic [W-1:0]      i_crop_w,
    input  logic [W-1:0]      i_crop_h,
    output logic              o_valid,
    output logic [2*W-1:0]    o_num,
    output logic [W-1:0]      o_den,
    output logic [SIDE_W-1:0] o_side
);
    import scl_pkg::*;

    localparam int SW = W + 3;

    // stage 1: pick and clamp the source region
    logic [W-1:0]  cx, cy, cw, ch;
    logic [SW-1:0] ex, ey, ew, eh, fw, fh;
    logic [SW-1:0] n1_rx, n1_ry, n1_rw, n1_rh;

    logic                 r1_vld;
    logic [W-1:0]         r1_rx, r1_ry;
    logic signed [SW-1:0] r1_rw, r1_rh;

    always_comb begin
        cx = i_dyn_crop_on ? i_dyn_crop_x : i_crop_x;
        cy = i_dyn_crop_on ? i_dyn_crop_y : i_crop_y;
        cw = i_dyn_crop_on ? i_dyn_crop_w : i_crop_w;
        ch = i_dyn_crop_on ? i_dyn_crop_h : i_crop_h;
        // round odd values up to even
        ex = {3'b000, cx} + SW'(cx[0]);
        ey = {3'b000, cy} + SW'(cy[0]);
        ew = {3'b000, cw} + SW'(cw[0]);
        eh = {3'b000, ch} + SW'(ch[0]);
        fw = {3'b000, i_frame_width};
        fh = {3'b000, i_frame_height};
        if (i_dyn_crop_on || i_crop_on) begin
            n1_rx = ex;
            n1_ry = ey;
            n1_rw = (ex + ew > fw) ? fw - ex : ew;   // may go negative
            n1_rh = (ey + eh > fh) ? fh - ey : eh;
        end else begin
            n1_rx = '0;
            n1_ry = '0;
            n1_rw = fw;
            n1_rh = fh;
        end
    end

    // stage 2: source range check and cross-products
    logic                 r2_vld, r2_src_bad;
    logic [W-1:0]         r2_rx, r2_ry, r2_rw, r2_rh;
    logic [2*W-1:0]       r2_pa, r2_pb;

    // stage 3: pick which side fills the output
    logic                 r3_vld, r3_src_bad, r3_sel_h;
    logic [W-1:0]         r3_rx, r3_ry, r3_rw, r3_rh;
    logic [2*W-1:0]       r3_num;
    logic [W-1:0]         r3_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else begin
            r1_vld <= i_valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_rx <= n1_rx[W-1:0];
        r1_ry <= n1_ry[W-1:0];
        r1_rw <= $signed(n1_rw);
        r1_rh <= $signed(n1_rh);

        r2_rx      <= r1_rx;
        r2_ry      <= r1_ry;
        r2_rw      <= r1_rw[W-1:0];
        r2_rh      <= r1_rh[W-1:0];
        r2_src_bad <= (r1_rw < $signed(SW'(SRC_MIN_W))) || (r1_rh < $signed(SW'(SRC_MIN_H)))
                   || (r1_rw > $signed(SW'(SRC_MAX)))   || (r1_rh > $signed(SW'(SRC_MAX)));
        r2_pa      <= {{W{1'b0}}, r1_rw[W-1:0]} * {{W{1'b0}}, i_out_height};
        r2_pb      <= {{W{1'b0}}, i_out_width}  * {{W{1'b0}}, r1_rh[W-1:0]};

        r3_rx      <= r2_rx;
        r3_ry      <= r2_ry;
        r3_rw      <= r2_rw;
        r3_rh      <= r2_rh;
        r3_src_bad <= r2_src_bad;
        r3_sel_h   <= r2_pa < r2_pb;
        // height-limited: pw = oh*rw/rh, else ph = ow*rh/rw
        r3_num     <= (r2_pa < r2_pb) ? r2_pa : r2_pb;
        r3_den     <= (r2_pa < r2_pb) ? r2_rh : r2_rw;
    end

    assign o_valid = r3_vld;
    assign o_num   = r3_num;
    assign o_den   = r3_den;
    assign o_side  = {r3_src_bad, r3_sel_h, r3_rx, r3_ry, r3_rw, r3_rh};

endmodule

// ===== rtl/scl_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with a
// sideband word carried alongside. Self-contained; uses scl_pkg only by import.
module scl_div #(
    parameter int W      = 13,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [2*W-1:0]    i_num,
    input  logic [W-1:0]      i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [W-1:0]      o_quot,
    output logic [SIDE_W-1:0] o_side
);
    import scl_pkg::*;

    // quotient is known to fit in W bits for every transaction that matters
    logic              r_vld  [W];
    logic [2*W-1:0]    r_rem  [W];
    logic [W-1:0]      r_den  [W];
    logic [W-1:0]      r_quot [W];
    logic [SIDE_W-1:0] r_side [W];

    for (genvar i = 0; i < W; i++) begin : g_stage
        localparam int K = W - 1 - i;

        logic              in_vld;
        logic [2*W-1:0]    in_rem, shifted, n_rem;
        logic [W-1:0]      in_den, in_quot, n_quot;
        logic [SIDE_W-1:0] in_side;
        logic              take;

        if (i == 0) begin : g_first
            assign in_vld  = i_valid;
            assign in_rem  = i_num;
            assign in_den  = i_den;
            assign in_quot = '0;
            assign in_side = i_side;
        end else begin : g_next
            assign in_vld  = r_vld[i-1];
            assign in_rem  = r_rem[i-1];
            assign in_den  = r_den[i-1];
            assign in_quot = r_quot[i-1];
            assign in_side = r_side[i-1];
        end

        assign shifted = {{W{1'b0}}, in_den} << K;
        assign take    = in_rem >= shifted;
        assign n_rem   = take ? in_rem - shifted : in_rem;
        assign n_quot  = in_quot | (take ? (W'(1) << K) : '0);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i] <= 1'b0;
            end else begin
                r_vld[i] <= in_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[i]  <= n_rem;
            r_den[i]  <= in_den;
            r_quot[i] <= n_quot;
            r_side[i] <= in_side;
        end
    end

    assign o_valid = r_vld[W-1];
    assign o_quot  = r_quot[W-1];
    assign o_side  = r_side[W-1];

endmodule

// ===== rtl/scl_back.sv =====
// Back pipeline: placement rectangle, destination and scale checks,
// error priority and the result register. Uses scl_pkg.
module scl_back #(
    parameter int  W      = 13,
    localparam int SIDE_W = 4 * W + 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [W-1:0]      i_quot,
    input  logic [SIDE_W-1:0] i_side,
    input  logic [W-1:0]      i_out_width,
    input  logic [W-1:0]      i_out_height,
    input  logic              i_lbox_en,
    output logic              o_done,
    output logic [2:0]        o_error_code,
    output logic [W-1:0]      o_read_x,
    output logic [W-1:0]      o_read_y,
    output logic [W-1:0]      o_read_w,
    output logic [W-1:0]      o_read_h,
    output logic [W-1:0]      o_place_x,
    output logic [W-1:0]      o_place_y,
    output logic [W-1:0]      o_place_w,
    output logic [W-1:0]      o_place_h,
    output logic              o_content_valid
);
    import scl_pkg::*;

    logic         src_bad, sel_h;
    logic [W-1:0] rx, ry, rw, rh;
    logic [W-1:0] n4_pw, n4_ph, n4_px, n4_py;

    assign {src_bad, sel_h, rx, ry, rw, rh} = i_side;

    always_comb begin
        n4_pw = i_out_width;
        n4_ph = i_out_height;
        if (i_lbox_en) begin
            if (sel_h) begin
                n4_pw = i_quot;
            end else begin
                n4_ph = i_quot;
            end
        end
        // placed size never exceeds the output size, so these stay positive
        n4_px = (i_out_width - n4_pw) >> 1;
        n4_py = (i_out_height - n4_ph) >> 1;
    end

    logic         r4_vld, r4_align_bad, r4_src_bad, r4_dst_bad, r4_keep;
    logic [W-1:0] r4_rx, r4_ry, r4_rw, r4_rh, r4_px, r4_py, r4_pw, r4_ph;

    logic         r_done, r_content_valid;
    logic [2:0]   r_error_code;
    logic [W-1:0] r_read_x, r_read_y, r_read_w, r_read_h;
    logic [W-1:0] r_place_x, r_place_y, r_place_w, r_place_h;

    // scale check: 1/8 <= d/s <= 8, exact
    logic [W+2:0] pw8, ph8, rw8, rh8, pw_e, ph_e, rw_e, rh_e;
    logic         scale_bad;
    t_err         err;

    always_comb begin
        pw8  = {r4_pw, 3'b000};
        ph8  = {r4_ph, 3'b000};
        rw8  = {r4_rw, 3'b000};
        rh8  = {r4_rh, 3'b000};
        pw_e = {3'b000, r4_pw};
        ph_e = {3'b000, r4_ph};
        rw_e = {3'b000, r4_rw};
        rh_e = {3'b000, r4_rh};
        scale_bad = (pw8 < rw_e) || (pw_e > rw8) || (ph8 < rh_e) || (ph_e > rh8);
        if (r4_align_bad) begin
            err = ERR_ALIGN;
        end else if (r4_src_bad) begin
            err = ERR_SRC;
        end else if (r4_dst_bad) begin
            err = ERR_DST;
        end else if (scale_bad) begin
            err = ERR_SCALE;
        end else begin
            err = ERR_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r4_vld <= i_valid;
            r_done <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_align_bad <= ((i_out_width % OUT_W_ALIGN) != 0) || i_out_height[0];
        r4_src_bad   <= src_bad;
        r4_dst_bad   <= (n4_pw < W'(DST_MIN_W)) || (n4_ph < W'(DST_MIN_H))
                     || (n4_pw > W'(DST_MAX))   || (n4_ph > W'(DST_MAX));
        r4_keep      <= i_lbox_en;
        r4_rx        <= rx;
        r4_ry        <= ry;
        r4_rw        <= rw;
        r4_rh        <= rh;
        r4_px        <= i_lbox_en ? n4_px : '0;
        r4_py        <= i_lbox_en ? n4_py : '0;
        r4_pw        <= n4_pw;
        r4_ph        <= n4_ph;

        r_error_code    <= err;
        r_content_valid <= (err == ERR_OK) && r4_keep;
        r_read_x        <= (err == ERR_OK) ? r4_rx : '0;
        r_read_y        <= (err == ERR_OK) ? r4_ry : '0;
        r_read_w        <= (err == ERR_OK) ? r4_rw : '0;
        r_read_h        <= (err == ERR_OK) ? r4_rh : '0;
        r_place_x       <= (err == ERR_OK) ? r4_px : '0;
        r_place_y       <= (err == ERR_OK) ? r4_py : '0;
        r_place_w       <= (err == ERR_OK) ? r4_pw : '0;
        r_place_h       <= (err == ERR_OK) ? r4_ph : '0;
    end

    assign o_done          = r_done;
    assign o_error_code    = r_error_code;
    assign o_content_valid = r_content_valid;
    assign o_read_x        = r_read_x;
    assign o_read_y        = r_read_y;
    assign o_read_w        = r_read_w;
    assign o_read_h        = r_read_h;
    assign o_place_x       = r_place_x;
    assign o_place_y       = r_place_y;
    assign o_place_w       = r_place_w;
    assign o_place_h       = r_place_h;

endmodule

// ===== rtl/scaler_crop_letterbox_placement_unit.sv =====
// Result strobe o_done is registered through the front, divider and back pipelines:
// 3 front stages, one divider stage per quotient bit, 2 back stages.
// Throughput: one transaction per cycle, set by the fully pipelined divider.
// busy is high only while reset is held; the result side has no backpressure.
// Reset (synchronous, active low) clears all valid bits and loads register defaults.
// Top level: instantiates scl_cfg, scl_front, scl_div and scl_back; uses scl_pkg.
module scaler_crop_letterbox_placement_unit #(
    parameter int COORD_BITS = 13
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [scl_pkg::PADDR_W-1:0] paddr,
    input  logic [scl_pkg::PDATA_W-1:0] pwdata,
    output logic [scl_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    input  logic                        start,
    output logic                        busy,
    input  logic [COORD_BITS-1:0]       i_frame_width,
    input  logic [COORD_BITS-1:0]       i_frame_height,
    input  logic                        i_dyn_crop_on,
    input  logic [COORD_BITS-1:0]       i_dyn_crop_x,
    input  logic [COORD_BITS-1:0]       i_dyn_crop_y,
    input  logic [COORD_BITS-1:0]       i_dyn_crop_w,
    input  logic [COORD_BITS-1:0]       i_dyn_crop_h,
    output logic                        o_done,
    output logic [2:0]                  o_error_code,
    output logic [COORD_BITS-1:0]       o_read_x,
    output logic [COORD_BITS-1:0]       o_read_y,
    output logic [COORD_BITS-1:0]       o_read_w,
    output logic [COORD_BITS-1:0]       o_read_h,
    output logic [COORD_BITS-1:0]       o_place_x,
    output logic [COORD_BITS-1:0]       o_place_y,
    output logic [COORD_BITS-1:0]       o_place_w,
    output logic [COORD_BITS-1:0]       o_place_h,
    output logic                        o_content_valid
);
    import scl_pkg::*;

    localparam int W      = COORD_BITS;
    localparam int SIDE_W = 4 * W + 2;
    localparam int LAT    = W + 5;

    logic [W-1:0]      out_width, out_height, crop_x, crop_y, crop_w, crop_h;
    logic              lbox_en, crop_on, accept;
    logic              f_valid, d_valid;
    logic [2*W-1:0]    f_num;
    logic [W-1:0]      f_den, d_quot;
    logic [SIDE_W-1:0] f_side, d_side;

    assign busy   = ~i_rst_n;
    assign accept = start & ~busy;

    scl_cfg #(.W(W)) u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_out_width  (out_width),
        .o_out_height (out_height),
        .o_lbox_en    (lbox_en),
        .o_crop_on    (crop_on),
        .o_crop_x     (crop_x),
        .o_crop_y     (crop_y),
        .o_crop_w     (crop_w),
        .o_crop_h     (crop_h)
    );

    scl_front #(.W(W)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (accept),
        .i_frame_width  (i_frame_width),
        .i_frame_height (i_frame_height),
        .i_dyn_crop_on  (i_dyn_crop_on),
        .i_dyn_crop_x   (i_dyn_crop_x),
        .i_dyn_crop_y   (i_dyn_crop_y),
        .i_dyn_crop_w   (i_dyn_crop_w),
        .i_dyn_crop_h   (i_dyn_crop_h),
        .i_out_width    (out_width),
        .i_out_height   (out_height),
        .i_crop_on      (crop_on),
        .i_crop_x       (crop_x),
        .i_crop_y       (crop_y),
        .i_crop_w       (crop_w),
        .i_crop_h       (crop_h),
        .o_valid        (f_valid),
        .o_num          (f_num),
        .o_den          (f_den),
        .o_side         (f_side)
    );

    scl_div #(.W(W), .SIDE_W(SIDE_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .i_num   (f_num),
        .i_den   (f_den),
        .i_side  (f_side),
        .o_valid (d_valid),
        .o_quot  (d_quot),
        .o_side  (d_side)
    );

    scl_back #(.W(W)) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (d_valid),
        .i_quot          (d_quot),
        .i_side          (d_side),
        .i_out_width     (out_width),
        .i_out_height    (out_height),
        .i_lbox_en       (lbox_en),
        .o_done          (o_done),
        .o_error_code    (o_error_code),
        .o_read_x        (o_read_x),
        .o_read_y        (o_read_y),
        .o_read_w        (o_read_w),
        .o_read_h        (o_read_h),
        .o_place_x       (o_place_x),
        .o_place_y       (o_place_y),
        .o_place_w       (o_place_w),
        .o_place_h       (o_place_h),
        .o_content_valid (o_content_valid)
    );

    // every accepted transaction produces a result strobe, and every strobe has an accepted transaction
    a_latency_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LAT o_done)
        else $error("result strobe missing after accepted transaction");

    a_latency_bwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(accept, LAT))
        else $error("result strobe without matching transaction");

    // an error result carries empty rectangles
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_error_code != ERR_OK) |->
            (o_read_w == '0 && o_place_w == '0 && o_place_h == '0 && !o_content_valid))
        else $error("error result with nonzero rectangle");

    // letterboxed content stays inside the output frame
    a_fit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_content_valid) |->
            ({1'b0, o_place_x, 1'b0} + {2'b00, o_place_w} <= {2'b00, out_width}
             && {1'b0, o_place_y, 1'b0} + {2'b00, o_place_h} <= {2'b00, out_height}))
        else $error("placement exceeds output frame");

endmodule
